// File: design/cartridge_bank_mapper_irq_defines.svh
// Assertion macros used by the checker file.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_DEFINES_SVH

// Property checked at each clock edge outside reset.
`define CBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at each clock edge, reset included.
`define CBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [2:0] REQ_WRITE_HIGH = 3'd0;
  localparam logic [2:0] REQ_WRITE_EXT  = 3'd1;
  localparam logic [2:0] REQ_READ       = 3'd2;
  localparam logic [2:0] REQ_TICK       = 3'd3;
  localparam logic [2:0] REQ_PRG_QUERY  = 3'd4;
  localparam logic [2:0] REQ_CHR_QUERY  = 3'd5;

  // Bus addresses that are decoded.
  localparam logic [15:0] ADDR_SELECT     = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
  localparam logic [15:0] ADDR_SELECT_EXT = 16'h8003;
  localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
  localparam logic [15:0] ADDR_IRQ_LATCH  = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_ACK    = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_OFF_A  = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ON_A   = 16'hE001;
  localparam logic [15:0] ADDR_IRQ_OFF_B  = 16'hE002;
  localparam logic [15:0] ADDR_IRQ_ON_B   = 16'hE003;
  localparam logic [15:0] ADDR_EXT_MODE   = 16'h5000;

  // Internal command codes from the decoder to the executor.
  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_BYTE_ONLY  = 4'd1;
  localparam logic [3:0] OP_SELECT     = 4'd2;
  localparam logic [3:0] OP_SELECT_EXT = 4'd3;
  localparam logic [3:0] OP_BANK_DATA  = 4'd4;
  localparam logic [3:0] OP_MIRROR     = 4'd5;
  localparam logic [3:0] OP_IRQ_LATCH  = 4'd6;
  localparam logic [3:0] OP_IRQ_ACK    = 4'd7;
  localparam logic [3:0] OP_IRQ_OFF    = 4'd8;
  localparam logic [3:0] OP_IRQ_ON     = 4'd9;
  localparam logic [3:0] OP_EXT_MODE   = 4'd10;
  localparam logic [3:0] OP_TICK       = 4'd11;
  localparam logic [3:0] OP_PRG_QUERY  = 4'd12;
  localparam logic [3:0] OP_CHR_QUERY  = 4'd13;

  // Configuration register indexes.
  localparam logic CFG_PRG_SIZE = 1'b0;
  localparam logic CFG_CHR_SIZE = 1'b1;

  // Reset values and magic numbers of the mapper.
  localparam int          PRG_SIZE_RESET   = 16;
  localparam int          CHR_SIZE_RESET   = 16;
  localparam logic [7:0]  PRG_RESET_BASE   = 8'(2 * PRG_SIZE_RESET - 4);
  localparam logic [8:0]  LAST_VISIBLE     = 9'd239;
  localparam logic [7:0]  EXT_LOCK_MASK    = 8'hA0;
  localparam logic [7:0]  SEL_PRG1_FIX     = 8'h2A;
  localparam logic [7:0]  SEL_PRG2_FIX     = 8'h28;
  localparam logic [7:0]  PRG1_FIX_PAGE    = 8'h0F;
  localparam logic [7:0]  PRG2_FIX_PAGE    = 8'h17;
  localparam logic [7:0]  PROT_HIGH        = 8'h83;
  localparam logic [7:0]  PROT_MID         = 8'h42;
  localparam logic [7:0]  PROT_LOW         = 8'h00;

  // Command queue between decoder and executor.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Remainder unit: 9-bit dividend, 10-bit divisor, one bit per cycle.
  localparam int DVD_W = 9;
  localparam int DVS_W = 10;
  localparam int CNT_W = $clog2(DVD_W + 1);

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data;
    logic [2:0] slot;
  } cmd_t;

  // Protection read value selected by the low bits of the last written byte.
  function automatic logic [7:0] prot_value(input logic [1:0] sel);
    logic [7:0] v;
    case (sel)
      2'd0:    v = PROT_HIGH;
      2'd1:    v = PROT_HIGH;
      2'd2:    v = PROT_MID;
      default: v = PROT_LOW;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/cbm_mod.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module cbm_mod (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [cbm_pkg::DVD_W-1:0]  dividend,
  input  wire logic [cbm_pkg::DVS_W-1:0]  divisor,
  output logic                            busy,
  output logic [cbm_pkg::DVD_W-1:0]       remainder
);

  logic [cbm_pkg::DVS_W-1:0] rem;
  logic [cbm_pkg::DVD_W-1:0] dvd;
  logic [cbm_pkg::DVS_W-1:0] dvs;
  logic [cbm_pkg::CNT_W-1:0] count;
  logic [cbm_pkg::DVS_W:0]   trial;
  logic [cbm_pkg::DVS_W:0]   diff;
  logic [cbm_pkg::DVS_W-1:0] rem_next;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial    = {rem, dvd[cbm_pkg::DVD_W-1]};
    diff     = trial - {1'b0, dvs};
    rem_next = (trial >= {1'b0, dvs}) ? diff[cbm_pkg::DVS_W-1:0]
                                      : trial[cbm_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= cbm_pkg::CNT_W'(cbm_pkg::DVD_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[cbm_pkg::DVD_W-2:0], 1'b0};
    end
  end

  assign busy      = (count != '0);
  assign remainder = rem[cbm_pkg::DVD_W-1:0];

endmodule

`default_nettype wire

// File: design/cbm_queue.sv
`default_nettype none

// Two-entry command queue between decoder and executor.
module cbm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cbm_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               nonempty,
  output cbm_pkg::cmd_t      head
);

  cbm_pkg::cmd_t              entry [cbm_pkg::QUEUE_DEPTH];
  logic [cbm_pkg::QPTR_W-1:0] wr_ptr;
  logic [cbm_pkg::QPTR_W-1:0] rd_ptr;
  logic [cbm_pkg::QPTR_W:0]   fill;

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

  assign full     = (fill == (cbm_pkg::QPTR_W + 1)'(cbm_pkg::QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign head     = entry[rd_ptr];

endmodule

`default_nettype wire

// File: design/cbm_front.sv
`default_nettype none

// Input side: take stream transactions and classify them into commands.
module cbm_front (
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [39:0]   s_tdata,
  input  wire logic [2:0]    s_tuser,
  input  wire logic          queue_full,
  output logic               push,
  output cbm_pkg::cmd_t      push_cmd
);

  logic [15:0] address;
  logic [7:0]  data;
  logic [8:0]  scanline;
  logic        rendering_on;
  logic [2:0]  slot;

  assign address      = s_tdata[15:0];
  assign data         = s_tdata[23:16];
  assign scanline     = s_tdata[32:24];
  assign rendering_on = s_tdata[33];
  assign slot         = s_tdata[36:34];

  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  // Decode request kind and address into one command
  always_comb begin
    push_cmd.data = data;
    push_cmd.slot = slot;
    unique case (s_tuser)
      cbm_pkg::REQ_WRITE_HIGH: begin
        unique case (address) inside
          cbm_pkg::ADDR_SELECT:     push_cmd.op = cbm_pkg::OP_SELECT;
          cbm_pkg::ADDR_SELECT_EXT: push_cmd.op = cbm_pkg::OP_SELECT_EXT;
          cbm_pkg::ADDR_BANK_DATA:  push_cmd.op = cbm_pkg::OP_BANK_DATA;
          cbm_pkg::ADDR_MIRROR:     push_cmd.op = cbm_pkg::OP_MIRROR;
          cbm_pkg::ADDR_IRQ_LATCH:  push_cmd.op = cbm_pkg::OP_IRQ_LATCH;
          cbm_pkg::ADDR_IRQ_ACK:    push_cmd.op = cbm_pkg::OP_IRQ_ACK;
          cbm_pkg::ADDR_IRQ_OFF_A,
          cbm_pkg::ADDR_IRQ_OFF_B:  push_cmd.op = cbm_pkg::OP_IRQ_OFF;
          cbm_pkg::ADDR_IRQ_ON_A,
          cbm_pkg::ADDR_IRQ_ON_B:   push_cmd.op = cbm_pkg::OP_IRQ_ON;
          default:                  push_cmd.op = cbm_pkg::OP_BYTE_ONLY;
        endcase
      end
      cbm_pkg::REQ_WRITE_EXT: begin
        push_cmd.op = (address == cbm_pkg::ADDR_EXT_MODE) ? cbm_pkg::OP_EXT_MODE
                                                          : cbm_pkg::OP_BYTE_ONLY;
      end
      cbm_pkg::REQ_TICK: begin
        // Only visible lines with rendering on reach the counter
        push_cmd.op = (scanline <= cbm_pkg::LAST_VISIBLE && rendering_on)
                      ? cbm_pkg::OP_TICK : cbm_pkg::OP_NONE;
      end
      cbm_pkg::REQ_PRG_QUERY: push_cmd.op = cbm_pkg::OP_PRG_QUERY;
      cbm_pkg::REQ_CHR_QUERY: push_cmd.op = cbm_pkg::OP_CHR_QUERY;
      default:                push_cmd.op = cbm_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: design/cbm_back.sv
`default_nettype none

// Executor: mapper state, configuration, page translation and result register.
module cbm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          cmd_valid,
  input  wire cbm_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [23:0]        m_tdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic       state;
  logic       state_next;

  logic [7:0] prg_size_16k;
  logic [6:0] chr_size_8k;

  logic [7:0] prg_page      [4];
  logic [7:0] prg_page_next [4];
  logic [8:0] chr_page      [8];
  logic [8:0] chr_page_next [8];
  logic [7:0] bank_shadow      [8];
  logic [7:0] bank_shadow_next [8];
  logic [7:0] ext_mode,    ext_mode_next;
  logic [7:0] select_mode, select_mode_next;
  logic       ext_active,  ext_active_next;
  logic       irq_enabled, irq_enabled_next;
  logic [7:0] irq_count,   irq_count_next;
  logic       irq_flag,    irq_flag_next;
  logic [7:0] last_byte,   last_byte_next;
  logic       mirror_bit,  mirror_bit_next;

  logic [7:0] last2;
  logic [7:0] last1;
  logic [7:0] dm;
  logic [7:0] ext_base;

  logic                       out_free;
  logic                       is_query;
  logic [cbm_pkg::DVD_W-1:0]  div_dividend;
  logic [cbm_pkg::DVS_W-1:0]  div_divisor;
  logic                       div_start;
  logic                       div_busy;
  logic [cbm_pkg::DVD_W-1:0]  div_rem;
  logic                       out_load;
  logic [8:0]                 out_page;

  // Last program pages, wrapping at 8 bits
  assign last2 = {prg_size_16k[6:0], 1'b0} - 8'd2;
  assign last1 = {prg_size_16k[6:0], 1'b0} - 8'd1;
  assign dm    = {cmd.data[7:1], 1'b0};

  // Query operands
  always_comb begin
    is_query = (cmd.op == cbm_pkg::OP_PRG_QUERY) || (cmd.op == cbm_pkg::OP_CHR_QUERY);
    if (cmd.op == cbm_pkg::OP_PRG_QUERY) begin
      div_dividend = {1'b0, prg_page[cmd.slot[1:0]]};
      div_divisor  = {1'b0, prg_size_16k, 1'b0};
    end else begin
      div_dividend = chr_page[cmd.slot];
      div_divisor  = {chr_size_8k, 3'b000};
    end
  end

  // Sequence one command at a time
  always_comb begin
    out_free   = !m_tvalid || m_tready;
    cmd_pop    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    out_page   = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (is_query && div_divisor != '0) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          out_load   = 1'b1;
          out_page   = div_rem;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Next mapper state for the popped command
  always_comb begin
    prg_page_next    = prg_page;
    chr_page_next    = chr_page;
    bank_shadow_next = bank_shadow;
    ext_mode_next    = ext_mode;
    select_mode_next = select_mode;
    ext_active_next  = ext_active;
    irq_enabled_next = irq_enabled;
    irq_count_next   = irq_count;
    irq_flag_next    = irq_flag;
    last_byte_next   = last_byte;
    mirror_bit_next  = mirror_bit;
    ext_base         = '0;
    if (cmd_pop) begin
      unique case (cmd.op)
        cbm_pkg::OP_BYTE_ONLY: last_byte_next = cmd.data;
        cbm_pkg::OP_SELECT: begin
          last_byte_next   = cmd.data;
          ext_active_next  = 1'b0;
          select_mode_next = cmd.data;
        end
        cbm_pkg::OP_SELECT_EXT: begin
          last_byte_next   = cmd.data;
          ext_active_next  = 1'b1;
          select_mode_next = cmd.data;
          if (cmd.data[7:4] == 4'd0) prg_page_next[2] = last2;
        end
        cbm_pkg::OP_BANK_DATA: begin
          last_byte_next = cmd.data;
          bank_shadow_next[select_mode[2:0]] = cmd.data;
          if (!ext_active) begin
            case (select_mode[2:0])
              3'd0: begin
                chr_page_next[4] = {1'b1, dm};
                chr_page_next[5] = {1'b1, dm[7:1], 1'b1};
                bank_shadow_next[select_mode[2:0]] = dm;
              end
              3'd1: begin
                chr_page_next[6] = {1'b1, dm};
                chr_page_next[7] = {1'b1, dm[7:1], 1'b1};
                bank_shadow_next[select_mode[2:0]] = dm;
              end
              3'd2: chr_page_next[0] = {1'b0, cmd.data};
              3'd3: chr_page_next[1] = {1'b0, cmd.data};
              3'd4: chr_page_next[2] = {1'b0, cmd.data};
              3'd5: chr_page_next[3] = {1'b0, cmd.data};
              3'd6: begin
                if ((ext_mode & cbm_pkg::EXT_LOCK_MASK) != cbm_pkg::EXT_LOCK_MASK)
                  prg_page_next[0] = cmd.data;
              end
              default: begin
                if ((ext_mode & cbm_pkg::EXT_LOCK_MASK) != cbm_pkg::EXT_LOCK_MASK)
                  prg_page_next[1] = cmd.data;
              end
            endcase
          end else if (select_mode == cbm_pkg::SEL_PRG1_FIX) begin
            prg_page_next[1] = cbm_pkg::PRG1_FIX_PAGE;
          end else if (select_mode == cbm_pkg::SEL_PRG2_FIX) begin
            prg_page_next[2] = cbm_pkg::PRG2_FIX_PAGE;
          end
        end
        cbm_pkg::OP_MIRROR: begin
          last_byte_next  = cmd.data;
          mirror_bit_next = !cmd.data[0];
        end
        cbm_pkg::OP_IRQ_LATCH: begin
          last_byte_next = cmd.data;
          irq_count_next = cmd.data;
          irq_flag_next  = 1'b0;
        end
        cbm_pkg::OP_IRQ_ACK: begin
          last_byte_next = cmd.data;
          irq_flag_next  = 1'b0;
        end
        cbm_pkg::OP_IRQ_OFF: begin
          last_byte_next   = cmd.data;
          irq_enabled_next = 1'b0;
          irq_flag_next    = 1'b0;
        end
        cbm_pkg::OP_IRQ_ON: begin
          last_byte_next   = cmd.data;
          irq_enabled_next = 1'b1;
          irq_flag_next    = 1'b0;
        end
        cbm_pkg::OP_EXT_MODE: begin
          last_byte_next = cmd.data;
          ext_mode_next  = cmd.data;
          if (cmd.data[7]) begin
            if (cmd.data[5]) begin
              // Four consecutive 8 KiB pages
              prg_page_next[0] = {2'b00, cmd.data[4:1], 2'd0};
              prg_page_next[1] = {2'b00, cmd.data[4:1], 2'd1};
              prg_page_next[2] = {2'b00, cmd.data[4:1], 2'd2};
              prg_page_next[3] = {2'b00, cmd.data[4:1], 2'd3};
            end else begin
              ext_base         = {2'b00, cmd.data[4:0], 1'b0};
              prg_page_next[2] = ext_base;
              prg_page_next[3] = {ext_base[7:1], 1'b1};
            end
          end else begin
            prg_page_next[0] = bank_shadow[6];
            prg_page_next[1] = bank_shadow[7];
            prg_page_next[2] = last2;
            prg_page_next[3] = last1;
          end
        end
        cbm_pkg::OP_TICK: begin
          if (irq_enabled) begin
            if (irq_count == 8'd0) begin
              irq_count_next   = 8'hFF;
              irq_enabled_next = 1'b0;
              irq_flag_next    = 1'b1;
            end else begin
              irq_count_next = irq_count - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_size_16k <= 8'(cbm_pkg::PRG_SIZE_RESET);
      chr_size_8k  <= 7'(cbm_pkg::CHR_SIZE_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        cbm_pkg::CFG_PRG_SIZE: prg_size_16k <= cfg_data;
        default:               chr_size_8k  <= cfg_data[6:0];
      endcase
    end
  end

  // Mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      for (int i = 0; i < 4; i++) prg_page[i] <= cbm_pkg::PRG_RESET_BASE + 8'(i);
      for (int i = 0; i < 8; i++) begin
        chr_page[i]    <= '0;
        bank_shadow[i] <= '0;
      end
      ext_mode    <= '0;
      select_mode <= '0;
      ext_active  <= 1'b0;
      irq_enabled <= 1'b0;
      irq_count   <= '0;
      irq_flag    <= 1'b0;
      last_byte   <= '0;
      mirror_bit  <= 1'b0;
    end else begin
      state       <= state_next;
      prg_page    <= prg_page_next;
      chr_page    <= chr_page_next;
      bank_shadow <= bank_shadow_next;
      ext_mode    <= ext_mode_next;
      select_mode <= select_mode_next;
      ext_active  <= ext_active_next;
      irq_enabled <= irq_enabled_next;
      irq_count   <= irq_count_next;
      irq_flag    <= irq_flag_next;
      last_byte   <= last_byte_next;
      mirror_bit  <= mirror_bit_next;
    end
  end

  cbm_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  // Result register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, out_page, mirror_bit_next, irq_flag_next,
                  cbm_pkg::prot_value(last_byte_next[1:0])};
    end
  end

endmodule

`default_nettype wire

// File: design/cartridge_bank_mapper_irq.sv
// Bank-switching cartridge mapper with a scanline interrupt counter.
// Requests enter on the s_ stream: tuser holds the request kind (bus write
// high, write to the 0x5000 area, protection read, scanline tick, program
// or character page query) and tdata the address, byte, scanline, render
// flag and window slot. Every request yields exactly one result on the m_
// stream: protection read value, interrupt line, mirroring and the mapped
// page (zero except for queries).
// A decoder classifies requests into a two-entry command queue; the
// executor runs one command at a time. A write, read or tick has its result
// registered once the executor takes it, and the executor takes one per cycle
// while the result stream is not stalled. A query holds the executor until
// its result is loaded: it starts the bit-serial remainder unit, which works
// through the page one bit at a time, then loads the result. A zero-size query
// answers like a write, with page zero.
// The cfg channel writes the ROM size registers (index 0 program, 1
// character); it is always ready and is meant to be used while idle.
// Synchronous reset loads the power-up bank layout and clears the queue and
// the result register. When m_tready is low the result holds, the executor
// waits, and the queue fills before s_tready drops.
`default_nettype none

module cartridge_bank_mapper_irq (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // address[15:0], data[23:16], scanline[32:24],
                                     // rendering_on[33], slot[36:34], zero[39:37]
  input  wire logic [2:0]  s_tuser,  // req_type[2:0]
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // read_data[7:0], irq_pending[8],
                                     // mirror_vertical[9], mapped_page[18:10], zero[23:19]
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic          push;
  cbm_pkg::cmd_t push_cmd;
  logic          queue_full;
  logic          pop;
  logic          queue_nonempty;
  cbm_pkg::cmd_t head;

  assign cfg_ready = 1'b1;

  cbm_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  cbm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .nonempty (queue_nonempty),
    .head     (head)
  );

  cbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (queue_nonempty),
    .cmd       (head),
    .cmd_pop   (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

// File: design/cbm_checker.sv
`default_nettype none
`include "cartridge_bank_mapper_irq_defines.svh"

// Port-level checks on the mapper.
module cbm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  logic stalled;
  logic prot_ok;

  assign stalled = m_tvalid && !m_tready;
  assign prot_ok = (m_tdata[7:0] == cbm_pkg::PROT_HIGH) ||
                   (m_tdata[7:0] == cbm_pkg::PROT_MID) ||
                   (m_tdata[7:0] == cbm_pkg::PROT_LOW);

  // A stalled result holds
  `CBM_ASSERT(a_out_hold, stalled |=> m_tvalid && $stable(m_tdata), "stalled result changed")

  // Reset empties the result register
  `CBM_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

  // Protection value is one of the table entries
  `CBM_ASSERT(a_prot_value, m_tvalid |-> prot_ok, "bad protection value")

  // Padding bits stay zero
  `CBM_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[23:19] == 5'd0, "nonzero padding in result")

endmodule

bind cartridge_bank_mapper_irq cbm_checker u_cbm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
